// File: design/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_defines.svh
// Assertion macros used by the checker of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Constants, byte source codes and the controller command bundle of the
// SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int ROUNDS      = 64;
   localparam int LEN_START   = 56;

   // byte pushed into the block buffer
   localparam logic [1:0] SRC_DATA  = 2'd0;
   localparam logic [1:0] SRC_PAD80 = 2'd1;
   localparam logic [1:0] SRC_ZERO  = 2'd2;
   localparam logic [1:0] SRC_LEN   = 2'd3;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic       push;
      logic [1:0] byte_src;
      logic [2:0] len_idx;
      logic       count_byte;
      logic       load_work;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic       finish;
      logic [2:0] out_idx;
   } cmd_type;

endpackage

// File: design/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer of the SHA-256 stream hasher: byte intake, padding, round count
// and digest hand-off.
// ----------------------------------------------------------------------------
module shs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_has_byte,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   output shs_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [5:0] FILL_LAST  = 6'(shs_pkg::BLOCK_BYTES - 1);
   localparam logic [5:0] FILL_LEN   = 6'(shs_pkg::LEN_START);
   localparam logic [5:0] ROUND_LAST = 6'(shs_pkg::ROUNDS - 1);

   logic [2:0] state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic       fin_ff, fin_in;
   logic       pad80_ff, pad80_in;
   logic       len_ff, len_in;
   logic       out_busy_ff, out_busy_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       in_acc;

   assign req_ready      = (state_ff == ST_IDLE);
   assign in_acc         = req_valid & req_ready;
   assign rsp_valid      = out_busy_ff;
   assign rsp_word_index = out_idx_ff;
   assign rsp_last_word  = (out_idx_ff == 3'd7);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      round_in    = round_ff;
      fin_in      = fin_ff;
      pad80_in    = pad80_ff;
      len_in      = len_ff;
      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      cmd         = '0;
      cmd.len_idx   = fill_ff[2:0];
      cmd.round_idx = round_ff;
      cmd.out_idx   = out_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               fin_in   = req_last;
               pad80_in = req_last;
               if (req_has_byte) begin
                  cmd.push       = 1'b1;
                  cmd.byte_src   = shs_pkg::SRC_DATA;
                  cmd.count_byte = 1'b1;
                  fill_in        = fill_ff + 6'd1;
               end
               if (req_has_byte && (fill_ff == FILL_LAST)) begin
                  cmd.load_work = 1'b1;
                  state_in      = ST_COMP;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            fill_in  = fill_ff + 6'd1;
            if (pad80_ff) begin
               cmd.byte_src = shs_pkg::SRC_PAD80;
               pad80_in     = 1'b0;
            end else if (len_ff || (fill_ff == FILL_LEN)) begin
               cmd.byte_src = shs_pkg::SRC_LEN;
               len_in       = 1'b1;
            end else begin
               cmd.byte_src = shs_pkg::SRC_ZERO;
            end
            if (fill_ff == FILL_LAST) begin
               cmd.load_work = 1'b1;
               state_in      = ST_COMP;
            end
         end
         ST_COMP: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_DONE: begin
            if (!out_busy_ff) begin
               cmd.finish  = 1'b1;
               out_busy_in = 1'b1;
               out_idx_in  = 3'd0;
               fin_in      = 1'b0;
               len_in      = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_busy_ff && rsp_ready) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == 3'd7) begin
            out_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         round_ff    <= '0;
         fin_ff      <= 1'b0;
         pad80_ff    <= 1'b0;
         len_ff      <= 1'b0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         round_ff    <= round_in;
         fin_ff      <= fin_in;
         pad80_ff    <= pad80_in;
         len_ff      <= len_in;
         out_busy_ff <= out_busy_in;
         out_idx_ff  <= out_idx_in;
      end
   end

endmodule

// File: design/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// Block shift buffer doubling as the rolling message schedule, working
// variables with one SHA-256 round per cycle, chaining words, bit count and
// digest output buffer.
// ----------------------------------------------------------------------------
module shs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  shs_pkg::cmd_type cmd,
   input  logic [7:0]       req_data_byte,
   output logic [31:0]      rsp_digest_word
);

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   logic [511:0] blk_ff, blk_in;
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];
   logic [31:0]  chain_ff [8];
   logic [31:0]  out_ff [8];
   logic [63:0]  bits_ff;
   logic [7:0]   push_byte;
   logic [31:0]  w0, w1, w9, w14, w_new;
   logic [31:0]  t1, t2, ch, maj;

   assign w0  = blk_ff[511:480];
   assign w1  = blk_ff[479:448];
   assign w9  = blk_ff[223:192];
   assign w14 = blk_ff[63:32];
   assign w_new = small_s1(w14) + w9 + small_s0(w1) + w0;

   always_comb begin
      case (cmd.byte_src)
         shs_pkg::SRC_DATA:  push_byte = req_data_byte;
         shs_pkg::SRC_PAD80: push_byte = shs_pkg::PAD_MARK;
         shs_pkg::SRC_LEN:   push_byte = bits_ff[{3'd7 - cmd.len_idx, 3'b000} +: 8];
         default:            push_byte = 8'h00;
      endcase
   end

   always_comb begin
      blk_in = blk_ff;
      if (cmd.push) begin
         blk_in = {blk_ff[503:0], push_byte};
      end else if (cmd.round) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
            (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big_s1(work_ff[4]) + ch + shs_pkg::ROUND_K[cmd.round_idx] + w0;
      t2  = big_s0(work_ff[0]) + maj;
      work_in[0] = t1 + t2;
      work_in[1] = work_ff[0];
      work_in[2] = work_ff[1];
      work_in[3] = work_ff[2];
      work_in[4] = work_ff[3] + t1;
      work_in[5] = work_ff[4];
      work_in[6] = work_ff[5];
      work_in[7] = work_ff[6];
   end

   assign rsp_digest_word = out_ff[cmd.out_idx];

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (cmd.load_work) begin
         work_ff <= chain_ff;
      end else if (cmd.round) begin
         work_ff <= work_in;
      end
      if (cmd.finish) begin
         out_ff <= chain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= shs_pkg::INIT_HASH;
         bits_ff  <= '0;
      end else begin
         if (cmd.finish) begin
            chain_ff <= shs_pkg::INIT_HASH;
            bits_ff  <= '0;
         end else begin
            if (cmd.fold) begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + work_ff[i];
               end
            end
            if (cmd.count_byte) begin
               bits_ff <= bits_ff + 64'd8;
            end
         end
      end
   end

endmodule

// File: design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input beats (req_) carry one byte when req_has_byte is set; req_last ends
// the message, with or without a byte. Result beats (rsp_) carry the digest
// words H0..H7, big-endian, indexed by rsp_word_index, rsp_last_word on H7.
// Data beats are accepted back to back until a block fills. The 64th byte
// of a block starts the compression, which runs one round per cycle in a
// single round unit, then a fold into the chaining words; req_ready is low
// meanwhile. On a last beat the padding is pushed one byte per cycle into
// the block buffer (spilling into an extra block when the length does not
// fit, with one more compression in between), followed by the final
// compression. rsp_valid rises after the last fold, once the output buffer is
// free, and the eight words then go out one per cycle while rsp_ready is high.
// The digest sits in its own output buffer: the next message is accepted
// while a stalled receiver holds words back; only the next digest hand-off
// waits for the buffer to drain.
// Reset (synchronous, active high) loads the initial hash values, clears
// the byte and bit counts and drops any pending digest words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   shs_pkg::cmd_type cmd;

   shs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   shs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

// File: design/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on digest beats and on req_ready after a last data beat.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module shs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_has_byte,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic rsp_beat;
   logic req_beat;

   assign rsp_beat = rsp_valid && rsp_ready;
   assign req_beat = req_valid && req_ready && req_has_byte && req_last;

   `SHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "digest beat changed while stalled")
   `SHS_ASSERT_NOW(a_last_flag, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last_word does not match word 7")
   `SHS_ASSERT_NEXT(a_word_seq, rsp_beat && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest words not back to back in order")
   `SHS_ASSERT_NEXT(a_digest_end, rsp_beat && rsp_last_word, !rsp_valid, "digest beat after word 7")
   `SHS_ASSERT_NEXT(a_finish_busy, req_beat, !req_ready, "input taken right after a finishing beat")

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
// Byte beats are fed over the req_ channel. Every accepted beat also goes
// into an in-bench SHA-256 model, which queues the eight digest words that
// each finished message should produce. Digest words from the rsp_ channel
// are checked in order against that queue.
// Stimulus: a few hand-picked messages, then random messages. Their lengths
// are biased toward the padding and block boundaries, and stray beats that
// carry no byte are mixed in. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int ITEM_TARGET    = 180;
   localparam int MIN_MESSAGES   = 5;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_beat_type;

   class digest_scoreboard;
      logic [31:0]  chain [8];
      logic [7:0]   block [64];
      int unsigned  fill;
      logic [63:0]  msg_bits;
      digest_beat_type pending_words [$];
      int unsigned  errors;
      int unsigned  words_checked;
      int unsigned  messages;
      int unsigned  bytes_hashed;

      function new();
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
         fill = 0;
         msg_bits = '0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [16];
         logic [31:0] v [8];
         logic [31:0] t1, t2, wt, x15, x2;
         for (int t = 0; t < 16; t++)
            w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
               wt = w[t];
            end else begin
               x15 = w[(t - 15) % 16];
               x2  = w[(t - 2) % 16];
               wt  = w[t % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                     + w[(t - 7) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
               w[t % 16] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      // one accepted req_ beat; a finishing beat queues the digest
      function void absorb_beat(logic [7:0] data, logic has_byte, logic last);
         digest_beat_type beat;
         if (has_byte) begin
            block[fill] = data;
            fill++;
            msg_bits = msg_bits + 64'd8;
            bytes_hashed++;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end
         if (!last) return;
         block[fill] = PAD_BYTE;
         fill++;
         if (fill > 56) begin
            while (fill < 64) begin
               block[fill] = 8'h00;
               fill++;
            end
            compress();
            fill = 0;
         end
         while (fill < 56) begin
            block[fill] = 8'h00;
            fill++;
         end
         for (int i = 0; i < 8; i++) block[56 + i] = msg_bits[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            beat.word      = chain[i];
            beat.index     = 3'(i);
            beat.last_word = (i == 7);
            pending_words.push_back(beat);
         end
         messages++;
         restart();
      endfunction

      function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last_word);
         digest_beat_type want;
         if (pending_words.size() == 0) begin
            $error("unexpected digest beat: word %h index %0d", word, index);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (word !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, word);
            errors++;
         end
         if (index !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, index);
            errors++;
         end
         if (last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word, last_word);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   int unsigned send_idle_pct = 14;
   int unsigned recv_idle_pct = 67;
   int unsigned data_items = 0;
   int unsigned idle_cycles = 0;

   digest_scoreboard board = new();

   sha256_stream_hasher uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_digest_word(rsp_digest_word, rsp_word_index, rsp_last_word);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sha256_stream_hasher test failed");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic [7:0] data, input logic has_byte, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_has_byte  <= has_byte;
      req_last      <= last;
      do @(posedge clock); while (!req_ready);
      board.absorb_beat(data, has_byte, last);
      if (has_byte || last) data_items++;
   endtask

   // hold the sender off until every queued digest word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_words.size() != 0);
   endtask

   task automatic send_message(input int unsigned len);
      logic bare;
      bare = 1'($urandom_range(1));
      if (len == 0) bare = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, !bare && (i == len - 1));
      end
      if (bare) send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int unsigned phase;
      int unsigned pick;
      int unsigned len;
      int unsigned random_msgs;
      int unsigned edge_lens [8];
      edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
      phase = 1;
      random_msgs = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty message, single-byte extremes, "abc" with a stray beat and
      // a bare finish carrying a byte that must be ignored, then another empty message
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'ha5, 1'b0, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'h5a, 1'b0, 1'b1);
      wait_drained();

      data_items = 0;
      while (data_items < ITEM_TARGET || random_msgs < MIN_MESSAGES) begin
         if (phase == 1 && data_items >= ITEM_TARGET / 3) begin
            wait_drained();
            send_idle_pct = 67;
            recv_idle_pct = 14;
            phase = 2;
         end else if (phase == 2 && data_items >= 2 * ITEM_TARGET / 3) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
            phase = 3;
         end
         pick = $urandom_range(99);
         if (pick < 20)      len = $urandom_range(8);
         else if (pick < 45) len = edge_lens[$urandom_range(7)];
         else if (pick < 85) len = $urandom_range(70);
         else                len = $urandom_range(140);
         send_message(len);
         random_msgs++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d messages, %0d message bytes, %0d digest words checked",
               board.messages, board.bytes_hashed, board.words_checked);
      $display("idle mixes: sender-light/receiver-heavy, reversed, and none");
      if (board.errors == 0)
         $display("sha256_stream_hasher test passed");
      else
         $display("sha256_stream_hasher test failed");
      $finish;
   end

endmodule
